>>> rtl/gbn_pkg.sv
package gbn_pkg;

    // Field widths
    localparam int DATA_W     = 31;
    localparam int CHUNK_W    = 9;
    localparam int WSIZE_W    = 5;
    localparam int TRIES_W    = 4;
    localparam int SEQ_W      = 32;
    localparam int KIND_W     = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = DATA_W + CHUNK_W;

    // Divider sequencing: one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MUL,
        ST_EMIT
    } state_t;

    // Transfer phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } phase_t;

    // Event opcodes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEARDOWN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GIVEUP   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIES  = 4'd3;

    // Configuration reset values
    localparam logic [CHUNK_W-1:0] CHUNK_RST  = 9'd1;
    localparam logic [WSIZE_W-1:0] WINDOW_RST = 5'd1;
    localparam logic [DATA_W-1:0]  DATA_RST   = 31'd1;
    localparam logic [TRIES_W-1:0] TRIES_RST  = 4'd10;

    // Protocol constants
    localparam logic [31:0]        ACK_TYPE_ACK = 32'd2;
    localparam logic [TRIES_W-1:0] TRIES_SAT    = 4'd15;

endpackage

>>> rtl/gbn_div.sv
// Restoring divider: data size over chunk size, one quotient bit per cycle
module gbn_div
    import gbn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [DATA_W-1:0]  dividend,
    input  logic [CHUNK_W-1:0] divisor,
    output logic               done,
    output logic [DATA_W-1:0]  quot,
    output logic [CHUNK_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CHUNK_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]    q_reg, q_next;
    logic [CHUNK_W-1:0]   dvs_reg, dvs_next;
    logic [CHUNK_W:0]     trial;
    logic [CHUNK_W:0]     diff;
    logic                 fits;

    // Shared subtract and compare for one bit
    always_comb
    begin
        trial = {acc_reg, q_reg[DATA_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Sequence the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            acc_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            acc_next = fits ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
            q_next   = {q_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = acc_reg;

endmodule

>>> rtl/go_back_n_sender.sv
// Go-back-N ARQ sender control. Events come in on the input channel (start,
// ack, timeout) and each one yields zero or more result words: data packet
// descriptors, or one teardown or give-up word, the final word of an event
// marked by last. The block takes one event at a time; in_ready is low until
// the event has been fully worked off. A start runs a bit-serial divider for
// packet_total = ceil(data_size / chunk_size), 31 steps, before the window
// begins. Every data descriptor then takes an offset multiply step and then
// a step to load the output register. An ack or timeout that sends a window
// of W packets, or a start, holds in_ready low until the last descriptor of
// that window is loaded, longer if the consumer stalls the output. After a
// write to chunk_size or data_size, the next event that sends a window first
// reruns the divider to refresh the short-packet length. Configuration is
// taken at any time on the cfg channel (cfg_ready is tied high) but must
// only be written while no event is in progress.
module go_back_n_sender
    import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // events
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [31:0]           ack_type,
    input  logic signed [31:0]    ack_seq,
    // results
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     kind,
    output logic [DATA_W-1:0]     seq_no,
    output logic [DATA_W-1:0]     byte_offset,
    output logic [CHUNK_W-1:0]    length,
    output logic                  last
);

    localparam int WIN_W = $clog2(WINDOW_MAX + 1);

    // Configuration registers
    logic [CHUNK_W-1:0] chunk_reg;
    logic [WSIZE_W-1:0] window_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [TRIES_W-1:0] tries_reg;

    // Sequencer and transfer state
    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic signed [SEQ_W-1:0]   base_reg, base_next;
    logic signed [SEQ_W-1:0]   hs_reg, hs_next;
    logic signed [SEQ_W-1:0]   ha_reg, ha_next;
    logic signed [SEQ_W-1:0]   pt_reg, pt_next;
    logic [TRIES_W-1:0]        retry_reg, retry_next;
    logic                      pend_reg, pend_next;
    logic [CHUNK_W-1:0]        rem_reg, rem_next;
    logic                      rem_ok_reg, rem_ok_next;
    logic                      upd_pt_reg, upd_pt_next;
    logic [WIN_W-1:0]          ctr_reg, ctr_next;
    logic [DATA_W-1:0]         seq_reg, seq_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [DATA_W-1:0]         seq_no_reg, seq_no_next;
    logic [DATA_W-1:0]         offset_reg, offset_next;
    logic [CHUNK_W-1:0]        length_reg, length_next;
    logic                      last_reg, last_next;

    // Divider hookup
    logic                      div_go;
    logic                      div_done;
    logic [DATA_W-1:0]         div_quot;
    logic [CHUNK_W-1:0]        div_rem;

    // Derived values
    logic [CHUNK_W-1:0]        chunk_eff;
    logic [WIN_W-1:0]          win;
    logic                      win_zero;
    logic                      in_fire;
    logic                      out_free;
    logic                      cfg_fire;
    logic                      done_cond;
    logic                      giveup_cond;
    logic                      ack_hit;
    logic signed [SEQ_W-1:0]   pt_m1;
    logic [DATA_W-1:0]         seq_calc;
    logic signed [PROD_W:0]    room;
    logic [CHUNK_W-1:0]        len_calc;
    logic                      emit_last;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamp chunk and window, evaluate end conditions and per-packet values
    always_comb
    begin
        chunk_eff   = (chunk_reg == '0) ? CHUNK_W'(1) : chunk_reg;
        win         = (32'(window_reg) > 32'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX)
                                                           : WIN_W'(window_reg);
        win_zero    = (win == '0);
        pt_m1       = pt_reg - 32'sd1;
        done_cond   = (ha_reg >= pt_m1);
        giveup_cond = (retry_reg >= tries_reg);
        ack_hit     = (ack_type == ACK_TYPE_ACK) && (ack_seq > ha_reg);
        seq_calc    = base_reg[DATA_W-1:0] + DATA_W'(ctr_reg);
        room        = $signed({10'b0, data_reg}) - $signed({1'b0, prod_reg});
        len_calc    = (room >= $signed({32'b0, chunk_eff})) ? chunk_eff : rem_reg;
        emit_last   = (ctr_reg == win - WIN_W'(1))
                      || ({1'b0, seq_reg} == $unsigned(pt_m1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_START)
                        state_next = ST_DIV;
                    else if ((opcode == OP_ACK || opcode == OP_TIMEOUT)
                             && phase_reg == PH_RUN)
                        state_next = ST_CHECK;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (done_cond || giveup_cond)
                begin
                    if (out_free)
                        state_next = ST_IDLE;
                end
                else if (pend_reg)
                begin
                    if (!rem_ok_reg)
                        state_next = ST_DIV;
                    else if (win_zero)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_MUL;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_MUL:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = emit_last ? ST_IDLE : ST_MUL;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        phase_next     = phase_reg;
        base_next      = base_reg;
        hs_next        = hs_reg;
        ha_next        = ha_reg;
        pt_next        = pt_reg;
        retry_next     = retry_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        rem_ok_next    = rem_ok_reg;
        upd_pt_next    = upd_pt_reg;
        ctr_next       = ctr_reg;
        seq_next       = seq_reg;
        prod_next      = prod_reg;
        kind_next      = kind_reg;
        seq_no_next    = seq_no_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        div_go         = 1'b0;

        // Drop the cached remainder when its operands change
        if (cfg_fire && (cfg_index == CFG_CHUNK || cfg_index == CFG_DATA))
            rem_ok_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (opcode)
                        OP_START:
                        begin
                            base_next   = '0;
                            hs_next     = -32'sd1;
                            ha_next     = -32'sd1;
                            retry_next  = '0;
                            pend_next   = 1'b1;
                            phase_next  = PH_RUN;
                            upd_pt_next = 1'b1;
                            div_go      = 1'b1;
                        end
                        OP_ACK:
                        begin
                            if (phase_reg == PH_RUN && ack_hit)
                            begin
                                ha_next    = ha_reg + 32'sd1;
                                base_next  = ha_reg + 32'sd2;
                                retry_next = '0;
                                pend_next  = ((ha_reg + 32'sd1) == hs_reg);
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            if (phase_reg == PH_RUN)
                            begin
                                if (retry_reg != TRIES_SAT)
                                    retry_next = retry_reg + TRIES_W'(1);
                                pend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rem_next    = div_rem;
                    rem_ok_next = 1'b1;
                    if (upd_pt_reg)
                        pt_next = $signed({1'b0, div_quot} + {31'b0, |div_rem});
                end
            end
            ST_CHECK:
            begin
                if (done_cond || giveup_cond)
                begin
                    // Final word: teardown wins over give-up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = done_cond ? KIND_TEARDOWN : KIND_GIVEUP;
                        seq_no_next    = '0;
                        offset_next    = '0;
                        length_next    = '0;
                        last_next      = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
                else if (pend_reg)
                begin
                    if (!rem_ok_reg)
                    begin
                        upd_pt_next = 1'b0;
                        div_go      = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        ctr_next  = '0;
                    end
                end
            end
            ST_MUL:
            begin
                // Compute the payload offset of this packet
                seq_next  = seq_calc;
                prod_next = PROD_W'(seq_calc) * PROD_W'(chunk_eff);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DATA;
                    seq_no_next    = seq_reg;
                    offset_next    = prod_reg[DATA_W-1:0];
                    length_next    = len_calc;
                    last_next      = emit_last;
                    if ($signed({1'b0, seq_reg}) > hs_reg)
                        hs_next = $signed({1'b0, seq_reg});
                    ctr_next = ctr_reg + WIN_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= CHUNK_RST;
            window_reg <= WINDOW_RST;
            data_reg   <= DATA_RST;
            tries_reg  <= TRIES_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_CHUNK:  chunk_reg  <= cfg_data[CHUNK_W-1:0];
                CFG_WINDOW: window_reg <= cfg_data[WSIZE_W-1:0];
                CFG_DATA:   data_reg   <= cfg_data[DATA_W-1:0];
                CFG_TRIES:  tries_reg  <= cfg_data[TRIES_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            base_reg      <= '0;
            hs_reg        <= -32'sd1;
            ha_reg        <= -32'sd1;
            pt_reg        <= '0;
            retry_reg     <= '0;
            pend_reg      <= 1'b1;
            rem_ok_reg    <= 1'b0;
            upd_pt_reg    <= 1'b0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            hs_reg        <= hs_next;
            ha_reg        <= ha_next;
            pt_reg        <= pt_next;
            retry_reg     <= retry_next;
            pend_reg      <= pend_next;
            rem_ok_reg    <= rem_ok_next;
            upd_pt_reg    <= upd_pt_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        seq_reg    <= seq_next;
        prod_reg   <= prod_next;
        kind_reg   <= kind_next;
        seq_no_reg <= seq_no_next;
        offset_reg <= offset_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    gbn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (data_reg),
        .divisor  (chunk_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign seq_no      = seq_no_reg;
    assign byte_offset = offset_reg;
    assign length      = length_reg;
    assign last        = last_reg;

endmodule

>>> rtl/gbn_checker.sv
// Port-level checks for the go-back-N sender
module gbn_checker
    import gbn_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [OP_W-1:0]       opcode,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [KIND_W-1:0]     kind,
    input logic [DATA_W-1:0]     seq_no,
    input logic [DATA_W-1:0]     byte_offset,
    input logic [CHUNK_W-1:0]    length,
    input logic                  last
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(seq_no)
            && $stable(byte_offset) && $stable(length) && $stable(last))
        else $error("result word changed while stalled");

    // Teardown and give-up words carry no packet and end the event
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> seq_no == '0 && byte_offset == '0
            && length == '0 && last)
        else $error("malformed end word");

    // A start always runs the divider, so the input side goes busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_START |=> !in_ready)
        else $error("input ready right after start");

    // Nothing follows an end word in the next cycle
    a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind != KIND_DATA |=> !out_valid)
        else $error("word after end word");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .seq_no      (seq_no),
    .byte_offset (byte_offset),
    .length      (length),
    .last        (last)
);
